// ===== rtl/gdad_pkg.sv =====
// Types, constants and calendar helpers for the Gregorian date adder.
// Shared by gdad_alu and gregorian_date_add_days; depends on nothing else.
`default_nettype none
package gdad_pkg;

	// Field widths of the two channels.
	localparam int DAYS_W  = 30;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int SYEAR_W = 20;
	localparam int YEAR_W  = 22;

	// Working widths: the ordinal holds a day-of-year plus the day count.
	localparam int ORD_W  = DAYS_W + 1;
	localparam int QUO_W  = 13;
	localparam int YMOD_W = 9;

	// Year divided by 400: drop four low bits, then an exact reciprocal of 25
	// over the remaining 16 bits. The quotient fits in 12 bits.
	localparam int YEAR_DROP  = 4;
	localparam int YEAR_RECIP = 83887;
	localparam int YEAR_SHIFT = 21;
	localparam int YPROD_W    = 33;

	// Ordinal divided by 146097: the top 18 bits times a floored reciprocal.
	// The estimate is never high and at most one below the true quotient.
	localparam int CYC_DROP  = 13;
	localparam int CYC_RECIP = 940737;
	localparam int CYC_SHIFT = 24;
	localparam int CPROD_W   = 38;

	// Calendar constants.
	localparam int CYCLE_DAYS  = 146097;
	localparam int CYCLE_YEARS = 400;
	localparam int YEAR_DAYS   = 365;
	localparam int LEAP_DAYS   = 366;
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	typedef struct packed {
		logic [DAYS_W-1:0]  days_to_add;
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [SYEAR_W-1:0] start_year;
	} item_t;

	typedef struct packed {
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YDIV,
		ST_YMOD,
		ST_ORD_INIT,
		ST_ORD_SUM,
		ST_ADD_N,
		ST_CDIV,
		ST_CMUL,
		ST_CFIX,
		ST_CYC_ADD,
		ST_YEARS,
		ST_MONTHS,
		ST_FINISH
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ORD_W-1:0] a;
		logic [ORD_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ORD_W-1:0] res;
		logic             borrow;
	} alu_rsp_t;

	// Leap test from the year taken modulo 400.
	function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
		logic century;
		century = (ymod == YMOD_W'(100)) || (ymod == YMOD_W'(200)) ||
			(ymod == YMOD_W'(300));
		return (ymod[1:0] == 2'b00) && !century;
	endfunction

	// Length of month m (1..12) in a year with the given leap flag.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
			MONTH_FEB:                len = leap ? DAY_W'(29) : DAY_W'(28);
			default:                  len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gdad_alu.sv =====
// Shared add/subtract unit used by every iteration of the date adder.
// Depends on gdad_pkg for the request and response types.
`default_nettype none
module gdad_alu (
	input  wire gdad_pkg::alu_req_t req,
	output gdad_pkg::alu_rsp_t rsp
);

	logic [gdad_pkg::ORD_W:0] sum;

	// One wide adder; subtraction reports a borrow when a is below b.
	always_comb begin
		if (req.op == gdad_pkg::ALU_SUB) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.res    = sum[gdad_pkg::ORD_W-1:0];
		rsp.borrow = (req.op == gdad_pkg::ALU_SUB) && sum[gdad_pkg::ORD_W];
	end

endmodule
`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: sequencer, registers and output stage.
// Depends on gdad_pkg and gdad_alu.
//
//  channel | signals                            | direction | payload
//  item    | item_valid, item_stall, item       | in        | days_to_add, start date
//  result  | result_valid, result_stall, result | out       | end date
//
// An item's result is loaded once the year is split by 400, up to 11 month sums are
// made, the ordinal is split by 146097 with at most one corrective subtract (both splits
// by reciprocal multiplies), and up to 399 year steps and up to 11 month steps are done.
// The next item is taken in the cycle after the load.
// Reset clears the sequencer and the result valid; no clearing pass is needed.
// A stalled result holds the next finished item in the finish state; item_stall is high
// from a transfer until the sequencer is back in idle.
`default_nettype none
module gregorian_date_add_days (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_stall,
	input  wire gdad_pkg::item_t     item,
	output logic                     result_valid,
	input  wire                      result_stall,
	output gdad_pkg::result_t        result
);

	localparam int ORD_W   = gdad_pkg::ORD_W;
	localparam int QUO_W   = gdad_pkg::QUO_W;
	localparam int YEAR_W  = gdad_pkg::YEAR_W;
	localparam int SYEAR_W = gdad_pkg::SYEAR_W;
	localparam int YMOD_W  = gdad_pkg::YMOD_W;
	localparam int MON_W   = gdad_pkg::MONTH_W;
	localparam int DAY_W   = gdad_pkg::DAY_W;
	localparam int YPROD_W = gdad_pkg::YPROD_W;
	localparam int CPROD_W = gdad_pkg::CPROD_W;

	gdad_pkg::state_t state_q, state_d;

	logic [gdad_pkg::DAYS_W-1:0] n_q, n_d;
	logic [DAY_W-1:0]            day_q, day_d;
	logic [MON_W-1:0]            mon_q, mon_d;
	logic [MON_W-1:0]            m_q, m_d;
	logic [YEAR_W-1:0]           year_q, year_d;
	logic [YMOD_W-1:0]           ymod_q, ymod_d;
	logic [ORD_W-1:0]            ord_q, ord_d;
	logic [ORD_W-1:0]            dvd_q, dvd_d;
	logic [QUO_W-1:0]            cq_q, cq_d;
	gdad_pkg::result_t           result_q;
	logic                        result_valid_q, result_valid_d;
	logic                        load_out;

	gdad_pkg::alu_req_t alu_req;
	gdad_pkg::alu_rsp_t alu_rsp;

	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic [DAY_W-1:0]   dclamp;
	logic [YPROD_W-1:0] yprod;
	logic [CPROD_W-1:0] cprod;
	logic [ORD_W-1:0]   yq_mul;
	logic [ORD_W-1:0]   cq_mul;
	logic [YEAR_W-1:0]  qext;

	gdad_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Combinational values used by the states.
	assign leap   = gdad_pkg::is_leap(ymod_q);
	assign yprod  = YPROD_W'(year_q[SYEAR_W-1:gdad_pkg::YEAR_DROP]) *
		YPROD_W'(gdad_pkg::YEAR_RECIP);
	assign cprod  = CPROD_W'(dvd_q[ORD_W-1:gdad_pkg::CYC_DROP]) *
		CPROD_W'(gdad_pkg::CYC_RECIP);
	assign yq_mul = (dvd_q << 8) + (dvd_q << 7) + (dvd_q << 4);
	assign cq_mul = ORD_W'(cq_q) * ORD_W'(gdad_pkg::CYCLE_DAYS);
	assign qext   = YEAR_W'(cq_q);

	// Sequencer: next state, ALU request and next register values.
	always_comb begin
		state_d        = state_q;
		n_d            = n_q;
		day_d          = day_q;
		mon_d          = mon_q;
		m_d            = m_q;
		year_d         = year_q;
		ymod_d         = ymod_q;
		ord_d          = ord_q;
		dvd_d          = dvd_q;
		cq_d           = cq_q;
		load_out       = 1'b0;
		alu_req.op     = gdad_pkg::ALU_ADD;
		alu_req.a      = ord_q;
		alu_req.b      = '0;
		mlen           = gdad_pkg::month_len(m_q, leap);
		dclamp         = '0;

		case (state_q)
			gdad_pkg::ST_IDLE: begin
				if (item_valid) begin
					n_d    = item.days_to_add;
					day_d  = item.start_day;
					if (item.start_month < gdad_pkg::MONTH_JAN) begin
						mon_d = gdad_pkg::MONTH_JAN;
					end else if (item.start_month > gdad_pkg::MONTH_DEC) begin
						mon_d = gdad_pkg::MONTH_DEC;
					end else begin
						mon_d = item.start_month;
					end
					year_d  = YEAR_W'(item.start_year);
					state_d = gdad_pkg::ST_YDIV;
				end
			end

			// Quotient of the start year by 400 from the reciprocal product.
			gdad_pkg::ST_YDIV: begin
				dvd_d   = ORD_W'(yprod[YPROD_W-1:gdad_pkg::YEAR_SHIFT]);
				state_d = gdad_pkg::ST_YMOD;
			end

			// The year residue is the year less 400 times the quotient.
			gdad_pkg::ST_YMOD: begin
				alu_req.op = gdad_pkg::ALU_SUB;
				alu_req.a  = ORD_W'(year_q);
				alu_req.b  = yq_mul;
				ymod_d     = alu_rsp.res[YMOD_W-1:0];
				state_d    = gdad_pkg::ST_ORD_INIT;
			end

			// Clamp the day into its month; the ordinal is kept zero-based.
			gdad_pkg::ST_ORD_INIT: begin
				mlen   = gdad_pkg::month_len(mon_q, leap);
				dclamp = (day_q == '0) ? DAY_W'(1) : day_q;
				if (dclamp > mlen) begin
					dclamp = mlen;
				end
				ord_d   = ORD_W'(dclamp - DAY_W'(1));
				m_d     = gdad_pkg::MONTH_JAN;
				state_d = gdad_pkg::ST_ORD_SUM;
			end

			// Add the lengths of the months before the start month.
			gdad_pkg::ST_ORD_SUM: begin
				alu_req.b = ORD_W'(mlen);
				if (m_q < mon_q) begin
					ord_d = alu_rsp.res;
					m_d   = m_q + MON_W'(1);
				end else begin
					state_d = gdad_pkg::ST_ADD_N;
				end
			end

			gdad_pkg::ST_ADD_N: begin
				alu_req.b = ORD_W'(n_q);
				dvd_d     = alu_rsp.res;
				state_d   = gdad_pkg::ST_CDIV;
			end

			// Estimate the number of whole 400-year cycles.
			gdad_pkg::ST_CDIV: begin
				cq_d    = cprod[gdad_pkg::CYC_SHIFT+QUO_W-1:gdad_pkg::CYC_SHIFT];
				state_d = gdad_pkg::ST_CMUL;
			end

			// Remainder left by the estimated cycle count.
			gdad_pkg::ST_CMUL: begin
				alu_req.op = gdad_pkg::ALU_SUB;
				alu_req.a  = dvd_q;
				alu_req.b  = cq_mul;
				ord_d      = alu_rsp.res;
				state_d    = gdad_pkg::ST_CFIX;
			end

			// Take out one more cycle while the remainder still holds one.
			gdad_pkg::ST_CFIX: begin
				alu_req.op = gdad_pkg::ALU_SUB;
				alu_req.b  = ORD_W'(gdad_pkg::CYCLE_DAYS);
				if (!alu_rsp.borrow) begin
					ord_d = alu_rsp.res;
					cq_d  = cq_q + QUO_W'(1);
				end else begin
					state_d = gdad_pkg::ST_CYC_ADD;
				end
			end

			// Skip whole 400-year cycles; the remainder plus one is the new, one-based ordinal.
			gdad_pkg::ST_CYC_ADD: begin
				alu_req.b = ORD_W'(1);
				year_d    = year_q + (qext << 8) + (qext << 7) + (qext << 4);
				ord_d     = alu_rsp.res;
				state_d   = gdad_pkg::ST_YEARS;
			end

			// Step year by year while the ordinal passes the year's end.
			gdad_pkg::ST_YEARS: begin
				alu_req.op = gdad_pkg::ALU_SUB;
				alu_req.b  = leap ? ORD_W'(gdad_pkg::LEAP_DAYS) :
					ORD_W'(gdad_pkg::YEAR_DAYS);
				if (!alu_rsp.borrow && (alu_rsp.res != '0)) begin
					ord_d  = alu_rsp.res;
					year_d = year_q + YEAR_W'(1);
					ymod_d = (ymod_q == YMOD_W'(gdad_pkg::CYCLE_YEARS - 1)) ?
						'0 : ymod_q + YMOD_W'(1);
				end else begin
					m_d     = gdad_pkg::MONTH_JAN;
					state_d = gdad_pkg::ST_MONTHS;
				end
			end

			// Step month by month within the final year.
			gdad_pkg::ST_MONTHS: begin
				alu_req.op = gdad_pkg::ALU_SUB;
				alu_req.b  = ORD_W'(mlen);
				if ((m_q < gdad_pkg::MONTH_DEC) && !alu_rsp.borrow &&
					(alu_rsp.res != '0)) begin
					ord_d = alu_rsp.res;
					m_d   = m_q + MON_W'(1);
				end else begin
					state_d = gdad_pkg::ST_FINISH;
				end
			end

			// Hand the date to the output register once it is free.
			gdad_pkg::ST_FINISH: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = gdad_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = gdad_pkg::ST_IDLE;
			end
		endcase

		// Output valid: set on load, cleared on a transfer.
		result_valid_d = result_valid_q;
		if (load_out) begin
			result_valid_d = 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_d = 1'b0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gdad_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= result_valid_d;
		end
	end

	// Working registers and the output register.
	always_ff @(posedge clk) begin
		n_q    <= n_d;
		day_q  <= day_d;
		mon_q  <= mon_d;
		m_q    <= m_d;
		year_q <= year_d;
		ymod_q <= ymod_d;
		ord_q  <= ord_d;
		dvd_q  <= dvd_d;
		cq_q   <= cq_d;
		if (load_out) begin
			result_q.end_day   <= ord_q[DAY_W-1:0];
			result_q.end_month <= m_q;
			result_q.end_year  <= year_q;
		end
	end

	assign item_stall   = (state_q != gdad_pkg::ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// A result appears only after the sequencer has finished an item.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == gdad_pkg::ST_FINISH))
		else $error("result valid rose without a finished item");

	// During the year steps the ordinal stays inside one 400-year cycle.
	a_years_ord_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdad_pkg::ST_YEARS) |->
		(ord_q != '0) && (ord_q <= ORD_W'(gdad_pkg::CYCLE_DAYS))
		&& (ymod_q < YMOD_W'(gdad_pkg::CYCLE_YEARS)))
		else $error("ordinal or year residue out of range in year steps");

	// Month steps start with an ordinal that fits in one year.
	a_months_ord_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdad_pkg::ST_MONTHS) |->
		(ord_q != '0) && (ord_q <= ORD_W'(gdad_pkg::LEAP_DAYS))
		&& (m_q >= gdad_pkg::MONTH_JAN) && (m_q <= gdad_pkg::MONTH_DEC))
		else $error("ordinal or month out of range in month steps");

	// A delivered date has a nonzero day and a month from 1 to 12.
	a_result_date: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.end_day != '0) &&
		(result.end_month >= gdad_pkg::MONTH_JAN) &&
		(result.end_month <= gdad_pkg::MONTH_DEC))
		else $error("result date out of range");

	// After the cycle correction the remainder is below one full cycle.
	a_cycle_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdad_pkg::ST_CYC_ADD) |->
		(ord_q < ORD_W'(gdad_pkg::CYCLE_DAYS)))
		else $error("cycle remainder out of range");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_gregorian_date_add_days.sv =====
// Self-checking testbench for the Gregorian date adder: a directed table, then random dates.
// Each result is checked against a calendar predictor kept in this file.
// Depends on gdad_pkg and gregorian_date_add_days.
`timescale 1ns / 100ps
module tb_gregorian_date_add_days;

	localparam int RAND_ITEMS  = 1200;
	localparam int CALM_FIRST  = 300;
	localparam int CALM_LAST   = 500;
	localparam int DRAIN_AT    = 800;
	localparam int TAIL_CYCLES = 600;
	localparam int STALL_LIMIT = 5000;
	localparam int SHOW_LIMIT  = 10;
	localparam longint unsigned ERA_DAYS  = 146097;
	localparam longint unsigned ERA_YEARS = 400;
	localparam int N_ROWS = 22;
	localparam int DAYS_W  = gdad_pkg::DAYS_W;
	localparam int DAY_W   = gdad_pkg::DAY_W;
	localparam int MONTH_W = gdad_pkg::MONTH_W;
	localparam int SYEAR_W = gdad_pkg::SYEAR_W;
	localparam int YEAR_W  = gdad_pkg::YEAR_W;

	// One row of the directed table; want is used only when typed is set.
	typedef struct packed {
		bit                typed;
		gdad_pkg::item_t   stim;
		gdad_pkg::result_t want;
	} row_t;

	localparam gdad_pkg::result_t NO_WANT = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	gdad_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	gdad_pkg::result_t result;

	logic              calm = 1'b0;
	gdad_pkg::result_t pending_dates [$];
	int                mismatches = 0;
	int                idle_cycles = 0;

	// Directed rows: clamping, leap rules, era skip, field extremes and bit patterns.
	row_t dir_rows [0:N_ROWS-1] = '{
		'{1'b1, '{30'd0, 5'd15, 4'd6, 20'd2024}, '{5'd15, 4'd6, 22'd2024}},
		'{1'b1, '{30'd0, 5'd0, 4'd0, 20'd1}, '{5'd1, 4'd1, 22'd1}},
		'{1'b1, '{30'd0, 5'd30, 4'd2, 20'd2023}, '{5'd28, 4'd2, 22'd2023}},
		'{1'b1, '{30'd0, 5'd31, 4'd2, 20'd2024}, '{5'd29, 4'd2, 22'd2024}},
		'{1'b1, '{30'd0, 5'd31, 4'd15, 20'd100}, '{5'd31, 4'd12, 22'd100}},
		'{1'b1, '{30'd0, 5'd31, 4'd13, 20'd1900}, '{5'd31, 4'd12, 22'd1900}},
		'{1'b1, '{30'd0, 5'd31, 4'd4, 20'd7}, '{5'd30, 4'd4, 22'd7}},
		'{1'b1, '{30'd0, 5'd29, 4'd2, 20'd0}, '{5'd29, 4'd2, 22'd0}},
		'{1'b1, '{30'd1, 5'd31, 4'd12, 20'd1999}, '{5'd1, 4'd1, 22'd2000}},
		'{1'b1, '{30'd1, 5'd28, 4'd2, 20'd1900}, '{5'd1, 4'd3, 22'd1900}},
		'{1'b1, '{30'd1, 5'd28, 4'd2, 20'd2000}, '{5'd29, 4'd2, 22'd2000}},
		'{1'b1, '{30'd146097, 5'd1, 4'd1, 20'd2000}, '{5'd1, 4'd1, 22'd2400}},
		'{1'b1, '{30'd365, 5'd1, 4'd1, 20'd2001}, '{5'd1, 4'd1, 22'd2002}},
		'{1'b1, '{30'd1, 5'd31, 4'd1, 20'd0}, '{5'd1, 4'd2, 22'd0}},
		'{1'b0, '{30'h3FFFFFFF, 5'd31, 4'd12, 20'hFFFFF}, NO_WANT},
		'{1'b0, '{30'h3FFFFFFF, 5'd1, 4'd1, 20'd0}, NO_WANT},
		'{1'b0, '{30'h3FFFFFFF, 5'd31, 4'd15, 20'hFFFFF}, NO_WANT},
		'{1'b0, '{30'd366, 5'd1, 4'd3, 20'd2003}, NO_WANT},
		'{1'b0, '{30'd146096, 5'd1, 4'd1, 20'd2000}, NO_WANT},
		'{1'b0, '{30'h2AAAAAAA, 5'd21, 4'd10, 20'hAAAAA}, NO_WANT},
		'{1'b0, '{30'h15555555, 5'd10, 4'd5, 20'h55555}, NO_WANT},
		'{1'b0, '{30'd1000000, 5'd0, 4'd0, 20'd399}, NO_WANT}
	};

	gregorian_date_add_days dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #6 clk = ~clk;

	// Calendar rules of the predictor.
	function automatic bit leap_year(input longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint unsigned days_in_month(input int unsigned m,
		input longint unsigned y);
		case (m)
			4, 6, 9, 11: return 30;
			2:           return leap_year(y) ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	// Predict the date that lies days_to_add days after the (clamped) start date.
	function automatic gdad_pkg::result_t shifted_date(input gdad_pkg::item_t it);
		longint unsigned yr, ord, span, eras;
		int unsigned mon, m;
		gdad_pkg::result_t r;
		yr  = it.start_year;
		mon = it.start_month;
		ord = it.start_day;
		if (mon < 1) mon = 1;
		if (mon > 12) mon = 12;
		span = days_in_month(mon, yr);
		if (ord < 1) ord = 1;
		if (ord > span) ord = span;
		for (m = 1; m < mon; m++) ord += days_in_month(m, yr);
		ord += it.days_to_add;
		eras = (ord - 1) / ERA_DAYS;
		ord -= eras * ERA_DAYS;
		yr  += eras * ERA_YEARS;
		while (ord > (leap_year(yr) ? 366 : 365)) begin
			ord -= leap_year(yr) ? 366 : 365;
			yr++;
		end
		m = 1;
		while (m < 12 && ord > days_in_month(m, yr)) begin
			ord -= days_in_month(m, yr);
			m++;
		end
		r.end_day   = DAY_W'(ord);
		r.end_month = MONTH_W'(m);
		r.end_year  = YEAR_W'(yr);
		return r;
	endfunction

	// Random start dates and day counts, weighted toward era and century edges.
	function automatic gdad_pkg::item_t random_date_item();
		gdad_pkg::item_t it;
		int unsigned pick;
		longint unsigned count;
		pick = $urandom_range(99);
		if (pick < 40)
			it.start_year = SYEAR_W'($urandom_range(2500));
		else if (pick < 60)
			it.start_year = SYEAR_W'($urandom_range(2600) * 400 + $urandom_range(3) * 100
				+ $urandom_range(1));
		else
			it.start_year = SYEAR_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 80) begin
			it.start_month = MONTH_W'($urandom_range(1, 12));
			it.start_day   = DAY_W'($urandom_range(1, 31));
		end else begin
			it.start_month = MONTH_W'($urandom_range(15));
			it.start_day   = DAY_W'($urandom_range(31));
		end
		pick = $urandom_range(99);
		if (pick < 35)
			count = $urandom_range(800);
		else if (pick < 60)
			count = $urandom_range(3 * 146097);
		else if (pick < 70)
			count = longint'($urandom_range(1, 7000)) * ERA_DAYS + $urandom_range(730) - 365;
		else
			count = $urandom;
		it.days_to_add = DAYS_W'(count);
		return it;
	endfunction

	// Offer one item, with an optional idle gap first, and queue its expected date
	// once the transfer has taken place.
	task automatic offer_date(input gdad_pkg::item_t it, input bit typed,
		input gdad_pkg::result_t want, input bit allow_gap);
		gdad_pkg::result_t expected;
		expected = typed ? want : shifted_date(it);
		if (allow_gap) begin
			while ($urandom_range(99) < 16) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_dates.push_back(expected);
	endtask

	task automatic note_mismatch(input string what, input gdad_pkg::result_t want,
		input gdad_pkg::result_t got);
		if (mismatches < SHOW_LIMIT)
			$display("%0t: %s: expected %0d-%0d-%0d, got %0d-%0d-%0d", $realtime, what,
				want.end_year, want.end_month, want.end_day,
				got.end_year, got.end_month, got.end_day);
		mismatches++;
	endtask

	// Stimulus: reset, the directed table, then the random part.
	initial begin
		int unsigned idx;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[r])
			offer_date(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want, 1'b1);
		for (idx = 0; idx < RAND_ITEMS; idx++) begin
			if (idx == CALM_FIRST) calm <= 1'b1;
			if (idx == CALM_LAST) calm <= 1'b0;
			// Let the block drain completely once before going on.
			if (idx == DRAIN_AT) begin
				item_valid <= 1'b0;
				do @(posedge clk); while (pending_dates.size() != 0);
			end
			offer_date(random_date_item(), 1'b0, NO_WANT,
				!(idx >= CALM_FIRST && idx < CALM_LAST));
		end
		item_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatches += pending_dates.size();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: random stalls, and each transfer checked against the oldest expectation.
	always @(posedge clk) begin
		gdad_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_dates.size() == 0) begin
				note_mismatch("result with nothing expected", NO_WANT, result);
			end else begin
				want = pending_dates.pop_front();
				if (result.end_day !== want.end_day || result.end_month !== want.end_month
					|| result.end_year !== want.end_year)
					note_mismatch("wrong date", want, result);
			end
		end
		result_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
	end

	// Watchdog: too long without a transfer on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
